/* design/tpu_pkg.sv */
// ----------------------------------------------------------------------------
// tpu_pkg
// Shared types, constants and helpers of the tracker pattern unpacker.
// ----------------------------------------------------------------------------
package tpu_pkg;

  localparam int CHANNELS = 64;
  // address width of the per-channel memories
  localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  // channel number carried by a channel byte (low seven bits)
  localparam int CH_NUM_W = 7;

  // stored or partial cell; pres bits: note, instrument, volume, effect
  typedef struct packed {
    logic [7:0] param;
    logic [7:0] cmd;
    logic [7:0] vol;
    logic [7:0] ins;
    logic [7:0] note;
    logic [3:0] pres;
  } cell_t;

  typedef struct packed {
    logic             mask_we;
    logic             cell_we;
    logic [CH_AW-1:0] addr;
    logic [7:0]       mask;
    cell_t            entry;
  } mem_wr_t;

  typedef struct packed {
    logic [7:0] mask;
    cell_t      entry;
  } mem_rd_t;

  // result payload, last field in the lowest bits
  typedef struct packed {
    logic       effect_present;
    logic [7:0] effect_param;
    logic [7:0] effect_code;
    logic       volume_present;
    logic [7:0] volume_value;
    logic       instrument_present;
    logic [7:0] instrument_value;
    logic       note_present;
    logic [7:0] note_value;
    logic [5:0] channel_index;
    logic [7:0] row_index;
  } res_t;

  // channel named by a channel byte: low seven bits, minus one when nonzero
  function automatic logic [CH_NUM_W-1:0] chan_of(input logic [7:0] b);
    logic [CH_NUM_W-1:0] low;
    low = b[CH_NUM_W-1:0];
    return (low == '0) ? '0 : low - CH_NUM_W'(1);
  endfunction

endpackage

/* design/tpu_chan_mem.sv */
// ----------------------------------------------------------------------------
// tpu_chan_mem
// Per-channel mask and last-cell memories, registered read with
// write-to-read forwarding.
// ----------------------------------------------------------------------------
module tpu_chan_mem (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [tpu_pkg::CH_AW-1:0] rd_addr,
  input  tpu_pkg::mem_wr_t        wr,
  output tpu_pkg::mem_rd_t        rd
);

  logic [7:0]     mask_mem [tpu_pkg::CHANNELS];
  tpu_pkg::cell_t cell_mem [tpu_pkg::CHANNELS];

  logic [7:0]     mask_q;
  tpu_pkg::cell_t cell_q;
  logic           fwd_mask;
  logic           fwd_cell;
  logic [7:0]     fwd_mask_data;
  tpu_pkg::cell_t fwd_cell_data;

  always_ff @(posedge clk) begin
    if (wr.mask_we) begin
      mask_mem[wr.addr] <= wr.mask;
    end
    if (wr.cell_we) begin
      cell_mem[wr.addr] <= wr.entry;
    end
    mask_q        <= mask_mem[rd_addr];
    cell_q        <= cell_mem[rd_addr];
    fwd_mask_data <= wr.mask;
    fwd_cell_data <= wr.entry;
  end

  // a write at the same edge as the read returns the old word, so bypass it
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_mask <= 1'b0;
      fwd_cell <= 1'b0;
    end else begin
      fwd_mask <= wr.mask_we && (wr.addr == rd_addr);
      fwd_cell <= wr.cell_we && (wr.addr == rd_addr);
    end
  end

  assign rd.mask  = fwd_mask ? fwd_mask_data : mask_q;
  assign rd.entry = fwd_cell ? fwd_cell_data : cell_q;

endmodule

/* design/tpu_parser.sv */
// ----------------------------------------------------------------------------
// tpu_parser
// Parse state of the packed stream: channel, mask and field bytes, row
// counter, error latch and channel valid bits; builds the unpacked cell.
// ----------------------------------------------------------------------------
module tpu_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [7:0]       data_byte,
  input  logic             pattern_start,
  input  tpu_pkg::mem_rd_t rd,
  output tpu_pkg::mem_wr_t wr,
  output logic             emit,
  output logic             err_out,
  output tpu_pkg::res_t    res
);

  localparam logic [2:0] PH_CHAN  = 3'd0;
  localparam logic [2:0] PH_MASK  = 3'd1;
  localparam logic [2:0] PH_NOTE  = 3'd2;
  localparam logic [2:0] PH_INS   = 3'd3;
  localparam logic [2:0] PH_VOL   = 3'd4;
  localparam logic [2:0] PH_CMD   = 3'd5;
  localparam logic [2:0] PH_PARAM = 3'd6;

  logic [2:0]                   phase, phase_next, ph_e;
  logic [tpu_pkg::CH_AW-1:0]    cur_ch, cur_ch_next, ch_new;
  logic [7:0]                   cur_mask, cur_mask_next;
  logic [7:0]                   row, row_next, row_e;
  logic                         err, err_next, err_e;
  logic [tpu_pkg::CHANNELS-1:0] vbits, vbits_next, vb_e;
  tpu_pkg::cell_t               partial, partial_next;
  tpu_pkg::cell_t               copy, copy_next;
  tpu_pkg::cell_t               held, held_next;
  tpu_pkg::cell_t               b_base;
  logic [7:0]                   b_mask;
  logic [3:0]                   adv_bits;
  logic [3:0]                   sk;
  logic                         do_begin, do_adv;
  logic [tpu_pkg::CH_NUM_W-1:0] ch_num;
  logic                         over;

  // {found, phase} of the lowest requested field
  function automatic logic [3:0] seek(input logic [3:0] bits);
    logic [3:0] r;
    r = {1'b0, PH_CHAN};
    for (int k = 3; k >= 0; k--) begin
      if (bits[k]) r = {1'b1, 3'(PH_NOTE + 3'(k))};
    end
    return r;
  endfunction

  assign ch_num = tpu_pkg::chan_of(data_byte);
  assign over   = ch_num >= tpu_pkg::CH_NUM_W'(tpu_pkg::CHANNELS);
  assign ch_new = ch_num[tpu_pkg::CH_AW-1:0];

  always_comb begin
    // pattern start clears before the byte is processed
    ph_e  = pattern_start ? PH_CHAN : phase;
    row_e = pattern_start ? 8'd0 : row;
    err_e = pattern_start ? 1'b0 : err;
    vb_e  = pattern_start ? '0 : vbits;

    phase_next    = ph_e;
    cur_ch_next   = cur_ch;
    cur_mask_next = cur_mask;
    row_next      = row_e;
    err_next      = err_e;
    vbits_next    = vb_e;
    partial_next  = partial;
    copy_next     = copy;
    held_next     = held;
    wr            = '0;
    wr.addr       = cur_ch;
    emit          = 1'b0;
    err_out       = 1'b0;
    do_begin      = 1'b0;
    do_adv        = 1'b0;
    b_mask        = '0;
    b_base        = '0;
    adv_bits      = '0;

    if (!err_e) begin
      case (ph_e)
        PH_CHAN: begin
          if (data_byte == 8'd0) begin
            if (row_e != 8'hff) row_next = row_e + 8'd1;
          end else if (over) begin
            emit     = 1'b1;
            err_out  = 1'b1;
            err_next = 1'b1;
          end else begin
            cur_ch_next = ch_new;
            if (data_byte[7]) begin
              phase_next = PH_MASK;
              held_next  = rd.entry;
            end else begin
              do_begin = 1'b1;
              b_mask   = vb_e[ch_new] ? rd.mask : '0;
              b_base   = vb_e[ch_new] ? rd.entry : '0;
            end
          end
        end
        PH_MASK: begin
          do_begin   = 1'b1;
          b_mask     = data_byte;
          // first mask write of a pattern starts the channel from an empty cell
          b_base     = vb_e[cur_ch] ? held : '0;
          wr.mask_we = 1'b1;
          wr.cell_we = 1'b1;
          wr.mask    = data_byte;
          wr.entry   = b_base;
          vbits_next[cur_ch] = 1'b1;
        end
        PH_NOTE: begin
          partial_next.note    = data_byte;
          partial_next.pres[0] = 1'b1;
          copy_next.note       = data_byte;
          copy_next.pres[0]    = 1'b1;
          wr.cell_we = 1'b1;
          wr.entry   = copy_next;
          do_adv     = 1'b1;
          adv_bits   = cur_mask[3:0] & 4'b1110;
        end
        PH_INS: begin
          partial_next.ins     = data_byte;
          partial_next.pres[1] = 1'b1;
          copy_next.ins        = data_byte;
          copy_next.pres[1]    = 1'b1;
          wr.cell_we = 1'b1;
          wr.entry   = copy_next;
          do_adv     = 1'b1;
          adv_bits   = cur_mask[3:0] & 4'b1100;
        end
        PH_VOL: begin
          partial_next.vol     = data_byte;
          partial_next.pres[2] = 1'b1;
          copy_next.vol        = data_byte;
          copy_next.pres[2]    = 1'b1;
          wr.cell_we = 1'b1;
          wr.entry   = copy_next;
          do_adv     = 1'b1;
          adv_bits   = cur_mask[3:0] & 4'b1000;
        end
        PH_CMD: begin
          partial_next.cmd     = data_byte;
          partial_next.pres[3] = 1'b1;
          copy_next.cmd        = data_byte;
          copy_next.pres[3]    = 1'b1;
          wr.cell_we = 1'b1;
          wr.entry   = copy_next;
          phase_next = PH_PARAM;
        end
        PH_PARAM: begin
          partial_next.param = data_byte;
          copy_next.param    = data_byte;
          wr.cell_we = 1'b1;
          wr.entry   = copy_next;
          phase_next = PH_CHAN;
          emit       = 1'b1;
        end
        default: begin
          phase_next = PH_CHAN;
        end
      endcase
    end

    sk = seek(do_begin ? b_mask[3:0] : adv_bits);

    if (do_begin) begin
      cur_mask_next = b_mask;
      copy_next     = b_base;
      partial_next  = b_base;
      // reuse a remembered field only when its byte is not sent
      for (int k = 0; k < 4; k++) begin
        partial_next.pres[k] = b_base.pres[k] & ~b_mask[k] & b_mask[k+4];
      end
    end

    if (do_begin || do_adv) begin
      if (sk[3]) begin
        phase_next = sk[2:0];
      end else begin
        phase_next = PH_CHAN;
        emit       = 1'b1;
      end
    end

    wr.mask_we = wr.mask_we & go;
    wr.cell_we = wr.cell_we & go;

    res                    = '0;
    res.row_index          = row_e;
    res.channel_index      = 6'(cur_ch_next);
    res.note_present       = partial_next.pres[0];
    res.note_value         = partial_next.pres[0] ? partial_next.note : 8'd0;
    res.instrument_present = partial_next.pres[1];
    res.instrument_value   = partial_next.pres[1] ? partial_next.ins : 8'd0;
    res.volume_present     = partial_next.pres[2];
    res.volume_value       = partial_next.pres[2] ? partial_next.vol : 8'd0;
    res.effect_present     = partial_next.pres[3];
    res.effect_code        = partial_next.pres[3] ? partial_next.cmd : 8'd0;
    res.effect_param       = partial_next.pres[3] ? partial_next.param : 8'd0;
    if (err_out) res = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_CHAN;
      row   <= 8'd0;
      err   <= 1'b0;
      vbits <= '0;
    end else if (go) begin
      phase <= phase_next;
      row   <= row_next;
      err   <= err_next;
      vbits <= vbits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      cur_ch   <= cur_ch_next;
      cur_mask <= cur_mask_next;
      partial  <= partial_next;
      copy     <= copy_next;
      held     <= held_next;
    end
  end

endmodule

/* design/tracker_pattern_unpacker.sv */
// ----------------------------------------------------------------------------
// tracker_pattern_unpacker
// Byte-serial decoder of packed tracker pattern data into unpacked cells.
// ----------------------------------------------------------------------------
// a cell reaches m_tvalid through the byte stage and the output register
// throughput: one byte per unstalled cycle, set by one read and one write per
//   byte on the channel memories (forwarding covers back-to-back same channel)
// reset: clears parse phase, row counter, error latch and channel valid bits;
//   the channel memories are not swept, valid bits mask their contents
module tracker_pattern_unpacker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] pattern_start
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] row_index, [13:8] channel_index, [21:14] note_value, [22] note_present,
  // [30:23] instrument_value, [31] instrument_present, [39:32] volume_value,
  // [40] volume_present, [48:41] effect_code, [56:49] effect_param,
  // [57] effect_present, [63:58] zero
  output logic [63:0] m_tdata,
  output logic        m_tuser    // [0] error_flag
);

  logic                         v1;
  logic [7:0]                   b1;
  logic                         ps1;
  logic                         adv, go, accept;
  logic [tpu_pkg::CH_NUM_W-1:0] in_ch, b1_ch;
  logic [tpu_pkg::CH_AW-1:0]    rd_addr;
  tpu_pkg::mem_wr_t             wr;
  tpu_pkg::mem_rd_t             rd;
  logic                         emit, err_out;
  tpu_pkg::res_t                res, o_res;
  logic                         o_err;
  logic                         o_valid;

  assign adv      = !o_valid || m_tready;
  assign go       = v1 && adv;
  assign s_tready = !v1 || adv;
  assign accept   = s_tvalid && s_tready;

  // read address follows the byte that sits in the first stage next cycle
  assign in_ch   = tpu_pkg::chan_of(s_tdata);
  assign b1_ch   = tpu_pkg::chan_of(b1);
  assign rd_addr = accept ? in_ch[tpu_pkg::CH_AW-1:0] : b1_ch[tpu_pkg::CH_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b1  <= s_tdata;
      ps1 <= s_tuser;
    end
  end

  tpu_chan_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd      (rd)
  );

  tpu_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .go            (go),
    .data_byte     (b1),
    .pattern_start (ps1),
    .rd            (rd),
    .wr            (wr),
    .emit          (emit),
    .err_out       (err_out),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= go && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      o_res <= res;
      o_err <= err_out;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = 64'(o_res);
  assign m_tuser  = o_err;

endmodule
